[rtl/lzwd_pkg.sv]
package lzwd_pkg;

  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned LEN_W             = 24;
  localparam int unsigned DIST_W            = 12;
  localparam int unsigned FLAG_CNT_W        = 4;
  localparam int unsigned COPY_CNT_W        = 5;
  localparam int unsigned WINDOW_DEPTH_DEF  = 4096;
  localparam int unsigned FLAGS_PER_GROUP   = 8;
  localparam int unsigned COPY_BIAS         = 3;

  localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

  // Parse phases that take an input item, then the copy/emit sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HDR1,
    ST_HDR2,
    ST_HDR3,
    ST_FLAG,
    ST_ITEM,
    ST_TOK2,
    ST_RD,
    ST_WR,
    ST_OUT
  } state_t;

endpackage

[rtl/lzwd_window.sv]
module lzwd_window
  import lzwd_pkg::*;
#(
  parameter int unsigned DEPTH = WINDOW_DEPTH_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [BYTE_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] mem_q_r;
  logic              hit_r;
  logic [AW:0]       fill_r;
  logic [AW:0]       fill_nxt;
  logic              rd_valid;

  // Writes land at consecutive addresses from zero after reset, so every
  // address below the fill count holds real data; the rest still reads zero.
  assign rd_valid = fill_r[AW] || (rd_addr < fill_r[AW-1:0]);

  always_comb begin
    fill_nxt = fill_r;
    if (wr_en && !fill_r[AW]) begin
      fill_nxt = fill_r + {{AW{1'b0}}, 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      hit_r   <= rd_valid;
    end
  end

  assign rd_data = hit_r ? mem_q_r : '0;

endmodule

[rtl/lz77_window_decompressor.sv]
// LZ77 window decompressor: takes one compressed byte per input item and
// produces the decompressed bytes it causes, one per result item. A byte
// marked in_stream_first starts a new stream whenever it is accepted; header
// bytes 1 to 3 give a little-endian 24-bit length, clamped to the
// max_out_length register (cfg_wr_data, written with cfg_wr_en; the user
// must write it only while idle: the block does not enforce it). Header,
// flag and token first bytes produce nothing. An accepted literal is
// registered and presented in the cycle after. A back-reference produces
// its 3 to 18 bytes, fewer where the stream length runs out, one at a time
// through the single window memory (4096 bytes by default): each byte
// passes through a read state, a write state and an output state. The
// input is stalled during the copy. The window reads as zeros after reset
// with no clearing pass: a fill count marks which addresses have been
// written since reset. Each result carries out_last_of_run on the final
// byte from its input item and out_stream_end on the byte that completes
// the stream length; later bytes are dropped until the next first byte.
module lz77_window_decompressor
  import lzwd_pkg::*;
#(
  parameter int unsigned WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  // compressed input
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_byte,
  input  logic              in_stream_first,
  // decompressed output
  output logic              out_valid,
  input  logic              out_stall,
  output logic [BYTE_W-1:0] out_byte,
  output logic              out_last_of_run,
  output logic              out_stream_end
);

  localparam int unsigned AW = $clog2(WINDOW_DEPTH);

  state_t state_r, state_nxt;

  // stream control state
  logic [LEN_W-1:0]      max_len_r;
  logic [LEN_W-1:0]      bl_r, bl_nxt;
  logic [AW-1:0]         wp_r, wp_nxt;
  logic [BYTE_W-1:0]     flag_r, flag_nxt;
  logic [FLAG_CNT_W-1:0] flags_left_r, flags_left_nxt;
  logic [BYTE_W-1:0]     tok_r, tok_nxt;
  logic [AW-1:0]         src_r, src_nxt;
  logic [COPY_CNT_W-1:0] cnt_r, cnt_nxt;

  // output register
  logic [BYTE_W-1:0]     ob_r, ob_nxt;
  logic                  olast_r, olast_nxt;
  logic                  oend_r, oend_nxt;

  // window port
  logic                  win_we;
  logic [BYTE_W-1:0]     win_wdata;
  logic                  win_re;
  logic [BYTE_W-1:0]     win_rdata;

  logic                  accepting;
  logic                  in_acc;
  logic [LEN_W-1:0]      len_hdr;
  logic [LEN_W-1:0]      len_clamp;
  logic [LEN_W-1:0]      bl_dec;
  logic [COPY_CNT_W-1:0] cnt_dec;
  logic [FLAG_CNT_W-1:0] flags_dec;
  logic                  more_copy;
  logic [AW-1:0]         tok_dist;
  state_t                done_state;

  // Parse phases take an item; the emit sequencer holds the input off.
  assign accepting = (state_r == ST_IDLE) || (state_r == ST_HDR1) ||
                     (state_r == ST_HDR2) || (state_r == ST_HDR3) ||
                     (state_r == ST_FLAG) || (state_r == ST_ITEM) ||
                     (state_r == ST_TOK2);
  assign in_acc    = in_valid && accepting;

  assign len_hdr   = {in_byte, bl_r[2*BYTE_W-1:0]};
  assign len_clamp = (len_hdr > max_len_r) ? max_len_r : len_hdr;

  // The one decrementer on the remaining length, shared by literals and copies.
  assign bl_dec    = bl_r - {{(LEN_W-1){1'b0}}, 1'b1};
  assign cnt_dec   = cnt_r - {{(COPY_CNT_W-1){1'b0}}, 1'b1};
  assign flags_dec = flags_left_r - {{(FLAG_CNT_W-1){1'b0}}, 1'b1};
  assign more_copy = (cnt_r != '0) && (bl_r != '0);
  assign tok_dist  = AW'({tok_r[3:0], in_byte});

  // Where parsing resumes once the current item has delivered all its bytes.
  assign done_state = (bl_r == '0)            ? ST_IDLE :
                      (flags_dec == '0)       ? ST_FLAG : ST_ITEM;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE, ST_HDR1, ST_HDR2, ST_HDR3, ST_FLAG, ST_ITEM, ST_TOK2: begin
        if (in_acc) begin
          if (in_stream_first) begin
            state_nxt = ST_HDR1;
          end else begin
            case (state_r)
              ST_HDR1: state_nxt = ST_HDR2;
              ST_HDR2: state_nxt = ST_HDR3;
              ST_HDR3: state_nxt = (len_clamp == '0) ? ST_IDLE : ST_FLAG;
              ST_FLAG: state_nxt = ST_ITEM;
              ST_ITEM: state_nxt = flag_r[BYTE_W-1] ? ST_TOK2 : ST_OUT;
              ST_TOK2: state_nxt = ST_RD;
              default: state_nxt = ST_IDLE;
            endcase
          end
        end
      end
      ST_RD: state_nxt = ST_WR;
      ST_WR: state_nxt = ST_OUT;
      ST_OUT: begin
        if (!out_stall) begin
          state_nxt = more_copy ? ST_RD : done_state;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall       = !accepting;
    out_valid      = (state_r == ST_OUT);
    win_we         = 1'b0;
    win_wdata      = in_byte;
    win_re         = 1'b0;
    bl_nxt         = bl_r;
    wp_nxt         = wp_r;
    flag_nxt       = flag_r;
    flags_left_nxt = flags_left_r;
    tok_nxt        = tok_r;
    src_nxt        = src_r;
    cnt_nxt        = cnt_r;
    ob_nxt         = ob_r;
    olast_nxt      = olast_r;
    oend_nxt       = oend_r;
    case (state_r)
      ST_IDLE, ST_HDR1, ST_HDR2, ST_HDR3, ST_FLAG, ST_ITEM, ST_TOK2: begin
        if (in_acc) begin
          if (in_stream_first) begin
            // Abort whatever was running and start a fresh header.
            bl_nxt         = '0;
            flag_nxt       = '0;
            flags_left_nxt = '0;
            tok_nxt        = '0;
          end else begin
            case (state_r)
              ST_HDR1: bl_nxt = LEN_W'(in_byte);
              ST_HDR2: bl_nxt = {bl_r[LEN_W-1:2*BYTE_W], in_byte, bl_r[BYTE_W-1:0]};
              ST_HDR3: bl_nxt = len_clamp;
              ST_FLAG: begin
                flag_nxt       = in_byte;
                flags_left_nxt = FLAG_CNT_W'(FLAGS_PER_GROUP);
              end
              ST_ITEM: begin
                if (flag_r[BYTE_W-1]) begin
                  tok_nxt = in_byte;
                end else begin
                  // Literal: store in the window and present it.
                  win_we    = 1'b1;
                  win_wdata = in_byte;
                  wp_nxt    = wp_r + {{(AW-1){1'b0}}, 1'b1};
                  bl_nxt    = bl_dec;
                  cnt_nxt   = '0;
                  ob_nxt    = in_byte;
                  olast_nxt = 1'b1;
                  oend_nxt  = (bl_dec == '0);
                end
              end
              ST_TOK2: begin
                src_nxt = wp_r - tok_dist - {{(AW-1){1'b0}}, 1'b1};
                cnt_nxt = COPY_CNT_W'(tok_r[BYTE_W-1:4]) + COPY_CNT_W'(COPY_BIAS);
              end
              default: ;
            endcase
          end
        end
      end
      ST_RD: begin
        win_re  = 1'b1;
        src_nxt = src_r + {{(AW-1){1'b0}}, 1'b1};
      end
      ST_WR: begin
        // Copy the fetched byte forward; overlapping runs see it on the next read.
        win_we    = 1'b1;
        win_wdata = win_rdata;
        wp_nxt    = wp_r + {{(AW-1){1'b0}}, 1'b1};
        bl_nxt    = bl_dec;
        cnt_nxt   = cnt_dec;
        ob_nxt    = win_rdata;
        olast_nxt = (cnt_dec == '0) || (bl_dec == '0);
        oend_nxt  = (bl_dec == '0);
      end
      ST_OUT: begin
        if (!out_stall && !more_copy) begin
          flag_nxt       = {flag_r[BYTE_W-2:0], 1'b0};
          flags_left_nxt = flags_dec;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      max_len_r    <= LEN_MAX;
      bl_r         <= '0;
      wp_r         <= '0;
      flag_r       <= '0;
      flags_left_r <= '0;
      tok_r        <= '0;
    end else begin
      state_r      <= state_nxt;
      bl_r         <= bl_nxt;
      wp_r         <= wp_nxt;
      flag_r       <= flag_nxt;
      flags_left_r <= flags_left_nxt;
      tok_r        <= tok_nxt;
      if (cfg_wr_en) begin
        max_len_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    src_r   <= src_nxt;
    cnt_r   <= cnt_nxt;
    ob_r    <= ob_nxt;
    olast_r <= olast_nxt;
    oend_r  <= oend_nxt;
  end

  assign out_byte        = ob_r;
  assign out_last_of_run = olast_r;
  assign out_stream_end  = oend_r;

  lzwd_window #(
    .DEPTH (WINDOW_DEPTH),
    .AW    (AW)
  ) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (win_we),
    .wr_addr (wp_r),
    .wr_data (win_wdata),
    .rd_en   (win_re),
    .rd_addr (src_r),
    .rd_data (win_rdata)
  );

endmodule

[rtl/lzwd_checker.sv]
module lzwd_checker
  import lzwd_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input logic              in_stream_first,
  input logic              out_valid,
  input logic              out_stall,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_last_of_run,
  input logic              out_stream_end
);

  // hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_byte) &&
      $stable(out_last_of_run) && $stable(out_stream_end)))
    else $error("stalled result changed");

  // one item at a time: no input taken while a result is pending
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

  // the end of a stream is always the end of its run
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stream_end) |-> out_last_of_run)
    else $error("stream end without last of run");

  // a run that is not finished keeps the input held off
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last_of_run) |=> in_stall)
    else $error("input taken in the middle of a run");

  // a first byte emits nothing
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_stream_first) |=> !out_valid)
    else $error("result after a stream first byte");

endmodule

bind lz77_window_decompressor lzwd_checker u_lzwd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .in_stream_first (in_stream_first),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run),
  .out_stream_end  (out_stream_end)
);
